FILE: design/lfbc_pkg.sv
package lfbc_pkg;

    localparam int ALU_W     = 34;
    localparam int DIVD_W    = 33;
    localparam int STEP_W    = 6;
    localparam int MUL_STEPS = 16;
    localparam int DIV_STEPS = 33;

    typedef enum logic [1:0] {
        OP_RESET_CURSOR = 2'd0,
        OP_SET_PIXEL    = 2'd1,
        OP_KEEP_PIXELS  = 2'd2,
        OP_UNUSED       = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

FILE: design/lfbc_ram.sv
module lfbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lfbc_alu.sv
module lfbc_alu
    import lfbc_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] sum
);

    assign sum = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);

endmodule

FILE: design/led_frame_buffer_cursor_unit.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  opcode, red, green, blue, skip_count
// out       output     out_valid/out_stall found, kept_red, kept_green, kept_blue
// cfg       input      cfg_wr_en          cfg_wr_data (pixels per channel)
//
// Reset, set, unused opcodes and keep of zero pixels complete at accept; set writes at accept.
// Keep of a nonzero count runs 16 shift-add steps for channel * pixels per channel,
// 2 adds and 33 restoring divide steps, all on one shared 34-bit adder, then a buffer read.
// After reset a clearing pass zeroes all CHANNELS*PIXELS_PER_CHANNEL_MAX
// buffer entries with in_stall high. A held result on out does not
// block new transactions; a keep waits at its end until the result register frees.
module led_frame_buffer_cursor_unit
    import lfbc_pkg::*;
#(
    parameter int CHANNELS               = 8,
    parameter int PIXELS_PER_CHANNEL_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [15:0] skip_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [7:0]  kept_red,
    output logic [7:0]  kept_green,
    output logic [7:0]  kept_blue
);

    localparam int DEPTH  = CHANNELS * PIXELS_PER_CHANNEL_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD_PX,
        ST_ADD_CNT,
        ST_DIV,
        ST_LOOK,
        ST_READ,
        ST_RESULT
    } state_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [15:0] ch,
                                                   input logic [15:0] px);
        logic [31:0] flat;
        flat = {16'd0, ch} * 32'(PIXELS_PER_CHANNEL_MAX) + {16'd0, px};
        return flat[ADDR_W-1:0];
    endfunction

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [15:0]         ppc_reg;
    logic [15:0]         cursor_channel_reg;
    logic [15:0]         cursor_pixel_reg;
    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic                out_valid_reg;

    logic [DIVD_W-1:0]   acc_reg;
    logic [DIVD_W-1:0]   md_reg;
    logic [15:0]         mul_reg;
    logic [15:0]         rem_reg;
    logic [15:0]         cnt_m1_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                hit_reg;
    logic                found_reg;
    logic [23:0]         kept_reg;

    logic [15:0]         ppc_eff;
    logic                in_accept;
    logic                out_accept;
    opcode_t             op;
    logic                cursor_in_buf;
    logic [15:0]         px_inc;
    logic                px_roll;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [23:0]         ram_wdata;
    logic [23:0]         ram_rdata;
    alu_req_t            alu_req;
    logic [ALU_W-1:0]    alu_sum;
    logic [16:0]         div_shift;
    logic                div_neg;
    logic [16:0]         rem_inc;
    logic                rem_roll;
    logic                result_load;

    assign ppc_eff    = (ppc_reg == 16'd0) ? 16'(PIXELS_PER_CHANNEL_MAX) : ppc_reg;
    assign in_stall   = clearing_reg || (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign op         = opcode_t'(opcode);

    assign cursor_in_buf = (cursor_channel_reg < 16'(CHANNELS))
                        && (cursor_pixel_reg < 16'(PIXELS_PER_CHANNEL_MAX));
    assign px_inc  = cursor_pixel_reg + 16'd1;
    assign px_roll = (px_inc == ppc_eff);

    assign div_shift = {rem_reg, acc_reg[DIVD_W-1]};
    assign div_neg   = alu_sum[ALU_W-1];
    assign rem_inc   = {1'b0, rem_reg} + 17'd1;
    assign rem_roll  = (rem_inc == {1'b0, ppc_eff});

    assign result_load = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            ST_MUL:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = mul_reg[0] ? ALU_W'(md_reg) : '0;
            end
            ST_ADD_PX:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = ALU_W'(cursor_pixel_reg);
            end
            ST_ADD_CNT:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = ALU_W'(cnt_m1_reg);
            end
            ST_DIV:
            begin
                alu_req.a   = ALU_W'(div_shift);
                alu_req.b   = ALU_W'(ppc_eff);
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    lfbc_alu u_alu (
        .req (alu_req),
        .sum (alu_sum)
    );

    assign ram_we    = clearing_reg
                    || (in_accept && (op == OP_SET_PIXEL) && cursor_in_buf);
    assign ram_waddr = clearing_reg ? clr_addr_reg
                                    : pix_addr(cursor_channel_reg, cursor_pixel_reg);
    assign ram_wdata = clearing_reg ? 24'd0 : {red, green, blue};

    lfbc_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            step_reg           <= '0;
            ppc_reg            <= '0;
            cursor_channel_reg <= '0;
            cursor_pixel_reg   <= '0;
            clearing_reg       <= 1'b1;
            clr_addr_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ppc_reg <= cfg_wr_data;
            end

            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_accept)
                    begin
                        unique case (op)
                            OP_RESET_CURSOR:
                            begin
                                cursor_channel_reg <= '0;
                                cursor_pixel_reg   <= '0;
                            end
                            OP_SET_PIXEL:
                            begin
                                if (px_roll)
                                begin
                                    cursor_channel_reg <= cursor_channel_reg + 16'd1;
                                    cursor_pixel_reg   <= '0;
                                end
                                else
                                begin
                                    cursor_pixel_reg <= px_inc;
                                end
                            end
                            OP_KEEP_PIXELS:
                            begin
                                if (skip_count != 16'd0)
                                begin
                                    state_reg <= ST_MUL;
                                end
                            end
                            OP_UNUSED:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(MUL_STEPS - 1))
                    begin
                        state_reg <= ST_ADD_PX;
                    end
                end
                ST_ADD_PX:
                begin
                    state_reg <= ST_ADD_CNT;
                end
                ST_ADD_CNT:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (rem_roll)
                    begin
                        cursor_channel_reg <= acc_reg[15:0] + 16'd1;
                        cursor_pixel_reg   <= '0;
                    end
                    else
                    begin
                        cursor_channel_reg <= acc_reg[15:0];
                        cursor_pixel_reg   <= rem_inc[15:0];
                    end
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (result_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            acc_reg    <= '0;
            md_reg     <= DIVD_W'(ppc_eff);
            mul_reg    <= cursor_channel_reg;
            rem_reg    <= '0;
            cnt_m1_reg <= skip_count - 16'd1;
        end

        unique case (state_reg)
            ST_MUL:
            begin
                acc_reg <= alu_sum[DIVD_W-1:0];
                md_reg  <= {md_reg[DIVD_W-2:0], 1'b0};
                mul_reg <= {1'b0, mul_reg[15:1]};
            end
            ST_ADD_PX, ST_ADD_CNT:
            begin
                acc_reg <= alu_sum[DIVD_W-1:0];
            end
            ST_DIV:
            begin
                rem_reg <= div_neg ? div_shift[15:0] : alu_sum[15:0];
                acc_reg <= {acc_reg[DIVD_W-2:0], !div_neg};
            end
            ST_LOOK:
            begin
                hit_reg  <= (acc_reg < DIVD_W'(CHANNELS))
                         && (rem_reg < 16'(PIXELS_PER_CHANNEL_MAX));
                addr_reg <= pix_addr(acc_reg[15:0], rem_reg);
            end
            default:
            begin
            end
        endcase

        if (result_load)
        begin
            found_reg <= hit_reg;
            kept_reg  <= hit_reg ? ram_rdata : 24'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign kept_red   = kept_reg[23:16];
    assign kept_green = kept_reg[15:8];
    assign kept_blue  = kept_reg[7:0];

endmodule
